// File: design/icsp_pkg.sv
// Package with types, constants and slot-sequence functions for the two-wire serial frame engine.
package icsp_pkg;

	localparam int CMD_BITS_MAX = 8;
	localparam int HP_W = 8;
	localparam int CNT_W = 5;
	localparam int SHIFT_W = 24;
	localparam int RD_W = 16;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 24;
	localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 8'd4;

	typedef enum logic [2:0] {
		ACT_CMD = 3'd0,
		ACT_CMD16 = 3'd1,
		ACT_CMD14F = 3'd2,
		ACT_READ14 = 3'd3,
		ACT_READ8 = 3'd4,
		ACT_WORD16 = 3'd5,
		ACT_SEND24 = 3'd6,
		ACT_READ16 = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		PH_CMD,
		PH_LEAD,
		PH_DATA,
		PH_READ,
		PH_TAIL,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WAIT,
		ST_OUT
	} state_t;

	function automatic phase_t next_phase(input phase_t ph);
		phase_t nx;
		case (ph)
			PH_CMD: nx = PH_LEAD;
			PH_LEAD: nx = PH_DATA;
			PH_DATA: nx = PH_READ;
			PH_READ: nx = PH_TAIL;
			default: nx = PH_DONE;
		endcase
		return nx;
	endfunction

	function automatic logic [CNT_W-1:0] phase_len(input action_t act, input phase_t ph,
			input logic [3:0] clen);
		logic [CNT_W-1:0] n;
		n = '0;
		case (ph)
			PH_CMD: begin
				if (act == ACT_CMD || act == ACT_CMD16 || act == ACT_CMD14F ||
						act == ACT_READ14 || act == ACT_READ8) begin
					n = CNT_W'(clen);
				end
			end
			PH_LEAD: begin
				case (act)
					ACT_CMD14F: n = 5'd1;
					ACT_READ14: n = 5'd1;
					ACT_READ8: n = 5'd8;
					ACT_SEND24: n = 5'd4;
					ACT_READ16: n = 5'd12;
					default: n = '0;
				endcase
			end
			PH_DATA: begin
				case (act)
					ACT_CMD16: n = 5'd16;
					ACT_CMD14F: n = 5'd14;
					ACT_WORD16: n = 5'd16;
					ACT_SEND24: n = 5'd24;
					default: n = '0;
				endcase
			end
			PH_READ: begin
				case (act)
					ACT_READ14: n = 5'd14;
					ACT_READ8: n = 5'd8;
					ACT_READ16: n = 5'd16;
					default: n = '0;
				endcase
			end
			PH_TAIL: begin
				if (act == ACT_CMD14F || act == ACT_READ14) begin
					n = 5'd1;
				end
			end
			default: n = '0;
		endcase
		return n;
	endfunction

endpackage

// File: design/icsp_serial_frame_engine.sv
// Top level of the two-wire serial frame engine: transaction sequencer and slot output.
//
// Each transaction on the s_axis side requests one serial programming transaction. The
// block answers on the m_axis side with one transaction per programming clock pulse slot,
// in bus order, with tlast on the final slot. A request with no slots produces nothing.
// Per slot, tdata gives the driven level, whether the data line is driven, whether the
// slot samples a read bit, and the assembled read word on the last slot of read requests.
// The half_period register is written over the APB port at byte address 0.
// A request is taken only while the block is idle, and the block stays busy until its
// last slot has been taken. Each slot passes through a setup state in the sequencer,
// then a wait timed by the single shared pulse timer from half_period, then a state
// with tvalid high until the slot is taken. Each of the five sections of a transaction
// takes one more sequencer step to load, whether or not it is empty for the requested
// kind, and one more step closes the transaction. A transaction has at most 28 slots.
// Reset returns the block to idle and sets half_period to 4. When the receiver holds
// tready low, the current slot is held unchanged and the pulse timer waits for it.
module icsp_serial_frame_engine #(
	parameter int COMMAND_BITS_MAX = icsp_pkg::CMD_BITS_MAX
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// action[2:0], command_length[6:3], command[14:7], payload[38:15],
	// target_bits[54:39], zero fill[55].
	input logic [icsp_pkg::S_TDATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// data_level[0], data_driven[1], sample_slot[2], read_data[18:3], zero fill[23:19].
	output logic [icsp_pkg::M_TDATA_W-1:0] m_tdata,
	output logic m_tlast,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	icsp_pkg::state_t state_q, state_d;
	icsp_pkg::phase_t phase_q;
	icsp_pkg::action_t action_q;
	logic [3:0] clen_q;
	logic [7:0] cmd_q;
	logic [23:0] payload_q;
	logic [icsp_pkg::RD_W-1:0] rd_q;
	logic is_read_q;
	logic [icsp_pkg::SHIFT_W-1:0] shift_q;
	logic [icsp_pkg::CNT_W-1:0] cnt_q;
	logic [icsp_pkg::CNT_W-1:0] remain_q;
	logic [icsp_pkg::HP_W:0] timer_q;
	logic [icsp_pkg::HP_W-1:0] half_period_q;

	logic s_fire, m_fire, timer_done;
	logic [icsp_pkg::CNT_W-1:0] cur_len;
	logic [3:0] in_clen, in_clen_sat;
	icsp_pkg::action_t in_action;
	logic [icsp_pkg::CNT_W-1:0] in_total;
	logic [icsp_pkg::RD_W-1:0] in_rd;
	logic slot_level, slot_driven, slot_sample, slot_last;

	assign pready = 1'b1;
	assign prdata = {24'd0, half_period_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= icsp_pkg::HALF_PERIOD_RESET;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			half_period_q <= pwdata[icsp_pkg::HP_W-1:0];
		end
	end

	assign s_tready = (state_q == icsp_pkg::ST_IDLE);
	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;

	assign in_action = icsp_pkg::action_t'(s_tdata[2:0]);
	assign in_clen = s_tdata[6:3];
	assign in_clen_sat = (in_clen > 4'(COMMAND_BITS_MAX)) ?
		4'(COMMAND_BITS_MAX) : in_clen;

	always_comb begin
		in_total = icsp_pkg::phase_len(in_action, icsp_pkg::PH_CMD, in_clen_sat)
			+ icsp_pkg::phase_len(in_action, icsp_pkg::PH_LEAD, in_clen_sat)
			+ icsp_pkg::phase_len(in_action, icsp_pkg::PH_DATA, in_clen_sat)
			+ icsp_pkg::phase_len(in_action, icsp_pkg::PH_READ, in_clen_sat)
			+ icsp_pkg::phase_len(in_action, icsp_pkg::PH_TAIL, in_clen_sat);
		case (in_action)
			icsp_pkg::ACT_READ14: in_rd = {2'b00, s_tdata[52:39]};
			icsp_pkg::ACT_READ8: in_rd = {8'd0, s_tdata[46:39]};
			icsp_pkg::ACT_READ16: in_rd = s_tdata[54:39];
			default: in_rd = '0;
		endcase
	end

	assign cur_len = icsp_pkg::phase_len(action_q, phase_q, clen_q);
	assign timer_done = ({1'b0, half_period_q} == '0) ||
		(timer_q + 1'b1 >= {half_period_q, 1'b0});

	always_comb begin
		state_d = state_q;
		case (state_q)
			icsp_pkg::ST_IDLE: begin
				if (s_fire) begin
					state_d = icsp_pkg::ST_LOAD;
				end
			end
			icsp_pkg::ST_LOAD: begin
				if (phase_q == icsp_pkg::PH_DONE) begin
					state_d = icsp_pkg::ST_IDLE;
				end else if (cnt_q != '0) begin
					state_d = icsp_pkg::ST_WAIT;
				end
			end
			icsp_pkg::ST_WAIT: begin
				if (timer_done) begin
					state_d = icsp_pkg::ST_OUT;
				end
			end
			icsp_pkg::ST_OUT: begin
				if (m_fire) begin
					state_d = icsp_pkg::ST_LOAD;
				end
			end
			default: state_d = icsp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icsp_pkg::ST_IDLE;
			phase_q <= icsp_pkg::PH_DONE;
			cnt_q <= '0;
			remain_q <= '0;
			timer_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				icsp_pkg::ST_IDLE: begin
					if (s_fire) begin
						phase_q <= icsp_pkg::PH_CMD;
						cnt_q <= '0;
						remain_q <= in_total;
					end
				end
				icsp_pkg::ST_LOAD: begin
					timer_q <= '0;
					if (cnt_q == '0 && phase_q != icsp_pkg::PH_DONE) begin
						if (cur_len == '0) begin
							phase_q <= icsp_pkg::next_phase(phase_q);
						end else begin
							cnt_q <= cur_len;
						end
					end
				end
				icsp_pkg::ST_WAIT: begin
					timer_q <= timer_q + 1'b1;
				end
				icsp_pkg::ST_OUT: begin
					if (m_fire) begin
						cnt_q <= cnt_q - 1'b1;
						remain_q <= remain_q - 1'b1;
						if (cnt_q == 5'd1) begin
							phase_q <= icsp_pkg::next_phase(phase_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			action_q <= in_action;
			clen_q <= in_clen_sat;
			cmd_q <= s_tdata[14:7];
			payload_q <= s_tdata[38:15];
			rd_q <= in_rd;
			is_read_q <= (in_action == icsp_pkg::ACT_READ14) ||
				(in_action == icsp_pkg::ACT_READ8) || (in_action == icsp_pkg::ACT_READ16);
		end
		if (state_q == icsp_pkg::ST_LOAD && cnt_q == '0) begin
			case (phase_q)
				icsp_pkg::PH_CMD: shift_q <= {16'd0, cmd_q};
				icsp_pkg::PH_LEAD: shift_q <= (action_q == icsp_pkg::ACT_READ16) ?
					24'd1 : 24'd0;
				icsp_pkg::PH_DATA: shift_q <= payload_q;
				default: shift_q <= '0;
			endcase
		end else if (m_fire) begin
			shift_q <= {1'b0, shift_q[icsp_pkg::SHIFT_W-1:1]};
		end
	end

	always_comb begin
		slot_driven = 1'b1;
		slot_sample = 1'b0;
		case (phase_q)
			icsp_pkg::PH_READ: begin
				slot_driven = 1'b0;
				slot_sample = 1'b1;
			end
			icsp_pkg::PH_LEAD, icsp_pkg::PH_TAIL: begin
				slot_driven = (action_q != icsp_pkg::ACT_READ14);
			end
			default: ;
		endcase
		slot_level = slot_driven && shift_q[0];
		slot_last = (remain_q == 5'd1);
	end

	assign m_tvalid = (state_q == icsp_pkg::ST_OUT);
	assign m_tlast = slot_last;
	assign m_tdata = {5'd0, (slot_last && is_read_q) ? rd_q : 16'd0,
		slot_sample, slot_driven, slot_level};

endmodule

// File: tb/icsp_serial_frame_engine_test.sv
// Self-checking testbench for the two-wire serial frame engine: random and directed requests.
`timescale 1ns / 1ps

module icsp_serial_frame_engine_test;

	localparam logic [2:0] ADDR_HALF_PERIOD = 3'd0;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER_REQUESTS = 30;

	typedef struct packed {
		logic level;
		logic driven;
		logic sample;
		logic [icsp_pkg::RD_W-1:0] rdata;
		logic last;
	} slot_t;

	logic clk;
	logic arst_n;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [icsp_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [icsp_pkg::M_TDATA_W-1:0] m_tdata;
	logic m_tlast;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	logic [icsp_pkg::S_TDATA_W-1:0] pending_requests[$];
	slot_t expected_slots[$];
	slot_t next_slot;
	int error_count = 0;
	int requests_taken = 0;
	int slot_index = 0;
	bit request_taken = 1'b0;
	bit idling_on = 1'b1;
	int send_gap = 0;
	int ready_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	icsp_serial_frame_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic logic [icsp_pkg::S_TDATA_W-1:0] pack_request(
			input icsp_pkg::action_t act, input logic [3:0] clen, input logic [7:0] cmd,
			input logic [23:0] payload, input logic [15:0] target);
		return {1'b0, target, payload, cmd, clen, act};
	endfunction

	function automatic logic [icsp_pkg::S_TDATA_W-1:0] random_request();
		logic [3:0] clen;
		if ($urandom_range(0, 5) == 0)
			clen = 4'($urandom_range(9, 15));
		else
			clen = 4'($urandom_range(0, 8));
		return pack_request(icsp_pkg::action_t'(3'($urandom_range(0, 7))), clen,
			8'($urandom), 24'($urandom), 16'($urandom));
	endfunction

	function automatic void push_slot(input logic level, input logic driven,
			input logic sample);
		slot_t s;
		s.level = level;
		s.driven = driven;
		s.sample = sample;
		s.rdata = '0;
		s.last = 1'b0;
		expected_slots.push_back(s);
	endfunction

	function automatic void drive_bits(input logic [23:0] value, input int count);
		int i;
		for (i = 0; i < count; i++)
			push_slot(value[i], 1'b1, 1'b0);
	endfunction

	function automatic void read_bits(input int count);
		int i;
		for (i = 0; i < count; i++)
			push_slot(1'b0, 1'b0, 1'b1);
	endfunction

	// Appends the pulse slots that one request puts on the bus.
	function automatic void predict_frame(input logic [icsp_pkg::S_TDATA_W-1:0] word);
		icsp_pkg::action_t act;
		int clen;
		logic [7:0] cmd;
		logic [23:0] payload;
		logic [15:0] target;
		logic [15:0] rd;
		bit is_read;
		int first;
		slot_t s;
		act = icsp_pkg::action_t'(word[2:0]);
		clen = int'(word[6:3]);
		cmd = word[14:7];
		payload = word[38:15];
		target = word[54:39];
		rd = '0;
		is_read = 1'b0;
		first = expected_slots.size();
		if (clen > icsp_pkg::CMD_BITS_MAX)
			clen = icsp_pkg::CMD_BITS_MAX;
		case (act)
			icsp_pkg::ACT_CMD: drive_bits(24'(cmd), clen);
			icsp_pkg::ACT_CMD16: begin
				drive_bits(24'(cmd), clen);
				drive_bits(payload, 16);
			end
			icsp_pkg::ACT_CMD14F: begin
				drive_bits(24'(cmd), clen);
				push_slot(1'b0, 1'b1, 1'b0);
				drive_bits(payload, 14);
				push_slot(1'b0, 1'b1, 1'b0);
			end
			icsp_pkg::ACT_READ14: begin
				drive_bits(24'(cmd), clen);
				push_slot(1'b0, 1'b0, 1'b0);
				read_bits(14);
				push_slot(1'b0, 1'b0, 1'b0);
				rd = {2'b00, target[13:0]};
				is_read = 1'b1;
			end
			icsp_pkg::ACT_READ8: begin
				drive_bits(24'(cmd), clen);
				drive_bits(24'h0, 8);
				read_bits(8);
				rd = {8'h00, target[7:0]};
				is_read = 1'b1;
			end
			icsp_pkg::ACT_WORD16: drive_bits(payload, 16);
			icsp_pkg::ACT_SEND24: begin
				drive_bits(24'h0, 4);
				drive_bits(payload, 24);
			end
			default: begin
				drive_bits(24'h1, 4);
				drive_bits(24'h0, 8);
				read_bits(16);
				rd = target;
				is_read = 1'b1;
			end
		endcase
		if (expected_slots.size() > first) begin
			s = expected_slots.pop_back();
			s.last = 1'b1;
			if (is_read)
				s.rdata = rd;
			expected_slots.push_back(s);
		end
	endfunction

	// Request side: one transaction offered at a time, with random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || request_taken) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_requests.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				s_tvalid <= 1'b0;
				send_gap <= $urandom_range(0, 6);
			end else begin
				s_tdata <= pending_requests.pop_front();
				s_tvalid <= 1'b1;
			end
		end
	end

	// Slot side: random stalls plus one long hold-off that backs up the request side.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && requests_taken >= HOLD_AFTER_REQUESTS) begin
			m_tready <= 1'b0;
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (ready_gap > 0) begin
			m_tready <= 1'b0;
			ready_gap <= ready_gap - 1;
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			ready_gap <= $urandom_range(0, 6);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_slots.size() == 0) begin
					report_error($sformatf("slot %0d with no expectation, tdata %0h",
						slot_index, m_tdata));
				end else begin
					next_slot = expected_slots.pop_front();
					if (m_tdata[0] !== next_slot.level)
						report_error($sformatf("slot %0d data_level %0b expected %0b",
							slot_index, m_tdata[0], next_slot.level));
					if (m_tdata[1] !== next_slot.driven)
						report_error($sformatf("slot %0d data_driven %0b expected %0b",
							slot_index, m_tdata[1], next_slot.driven));
					if (m_tdata[2] !== next_slot.sample)
						report_error($sformatf("slot %0d sample_slot %0b expected %0b",
							slot_index, m_tdata[2], next_slot.sample));
					if (m_tdata[18:3] !== next_slot.rdata)
						report_error($sformatf("slot %0d read_data %0h expected %0h",
							slot_index, m_tdata[18:3], next_slot.rdata));
					if (m_tlast !== next_slot.last)
						report_error($sformatf("slot %0d last %0b expected %0b",
							slot_index, m_tlast, next_slot.last));
				end
				slot_index++;
			end
			request_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				predict_frame(s_tdata);
				requests_taken++;
			end
		end
	end

	task automatic drain();
		while (pending_requests.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_slots.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_half_period(input logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_HALF_PERIOD;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== value)
			report_error($sformatf("half_period reads %0h expected %0h", prdata[7:0], value));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_half_period(input logic [7:0] value);
		drain();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_HALF_PERIOD;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		check_half_period(value);
	endtask

	task automatic queue_random(input int count);
		int i;
		for (i = 0; i < count; i++)
			pending_requests.push_back(random_request());
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_half_period(icsp_pkg::HALF_PERIOD_RESET);

		pending_requests.push_back(pack_request(icsp_pkg::ACT_CMD, 4'd8, 8'hA5, 24'h0,
			16'h0));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_CMD, 4'd0, 8'hFF, 24'hFFFFFF,
			16'hFFFF));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_CMD, 4'd15, 8'h5A, 24'h0,
			16'h0));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_CMD16, 4'd8, 8'hFF, 24'hFFFFFF,
			16'h0));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_CMD16, 4'd0, 8'h00, 24'h000000,
			16'h0));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_CMD14F, 4'd4, 8'h0F, 24'hFFC000,
			16'h0));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_CMD14F, 4'd8, 8'h3C, 24'h003FFF,
			16'h0));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_READ14, 4'd1, 8'h01, 24'h0,
			16'hFFFF));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_READ14, 4'd9, 8'hC3, 24'h0,
			16'h2AAA));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_READ8, 4'd6, 8'h96, 24'h0,
			16'hFF00));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_READ8, 4'd8, 8'hFF, 24'hFFFFFF,
			16'h00FF));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_WORD16, 4'd12, 8'hFF, 24'hFF0000,
			16'h0));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_WORD16, 4'd0, 8'h00, 24'h00FFFF,
			16'h0));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_SEND24, 4'd15, 8'hFF, 24'hFFFFFF,
			16'h0));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_SEND24, 4'd3, 8'h81, 24'h000000,
			16'h0));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_READ16, 4'd8, 8'hFF, 24'hFFFFFF,
			16'hFFFF));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_READ16, 4'd0, 8'h00, 24'h0,
			16'h0000));
		pending_requests.push_back(pack_request(icsp_pkg::ACT_READ16, 4'd2, 8'h12, 24'h0,
			16'h8001));

		set_half_period(8'd1);
		queue_random(90);
		set_half_period(8'd0);
		queue_random(40);
		set_half_period(8'd255);
		queue_random(4);
		set_half_period(8'($urandom_range(2, 8)));
		queue_random(50);
		set_half_period(8'd2);
		idling_on = 1'b0;
		queue_random(40);
		drain();
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
